// ----- rtl/cell_color_vote_quantizer_top_defines.svh -----
// Assertion macros used by the top module to check itself.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef CELL_COLOR_VOTE_QUANTIZER_TOP_DEFINES_SVH
`define CELL_COLOR_VOTE_QUANTIZER_TOP_DEFINES_SVH

`define CCVQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CCVQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ccvq_pkg.sv -----
package ccvq_pkg;

  localparam int VOTE_SLOTS  = 9;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [3:0]  color_t;
  typedef logic [16:0] hue_t;

  localparam color_t COLOR_RED     = 4'd0;
  localparam color_t COLOR_GREEN   = 4'd1;
  localparam color_t COLOR_YELLOW  = 4'd2;
  localparam color_t COLOR_BLUE    = 4'd3;
  localparam color_t COLOR_MAGENTA = 4'd4;
  localparam color_t COLOR_CYAN    = 4'd5;
  localparam color_t COLOR_WHITE   = 4'd6;
  localparam color_t COLOR_LGREY   = 4'd7;
  localparam color_t COLOR_GREY    = 4'd8;
  localparam color_t COLOR_NORMAL  = 4'd9;

  localparam hue_t HUE_RED_HI     = 17'd350;
  localparam hue_t HUE_RED_LO     = 17'd45;
  localparam hue_t HUE_YELLOW_HI  = 17'd68;
  localparam hue_t HUE_GREEN_HI   = 17'd145;
  localparam hue_t HUE_CYAN_HI    = 17'd196;
  localparam hue_t HUE_BLUE_HI    = 17'd256;
  localparam hue_t HUE_SCALE      = 17'd60;
  localparam hue_t HUE_SECTOR_G   = 17'd120;
  localparam hue_t HUE_SECTOR_B   = 17'd240;
  localparam hue_t HUE_FULL_TURN  = 17'd360;

  localparam logic REG_IMAGE_MODE = 1'b0;

  typedef struct packed {
    logic   vote;
    color_t code;
    logic   bright;
    logic   last;
  } vote_item_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_SCAN,
    BK_DONE
  } back_state_t;

endpackage

// ----- rtl/ccvq_front.sv -----
module ccvq_front
  import ccvq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  input  logic       in_last_of_cell,
  output logic       full,
  output logic       q_push,
  output vote_item_t q_item,
  input  logic       q_full
);

  logic       pv_r, pv_nxt;
  logic [7:0] red_r, green_r, blue_r, alpha_r;
  logic       last_r;
  logic       accept;

  logic       r_max, g_max, grey, opaque;
  logic [7:0] mx, mn, d;
  hue_t       dw, hd;
  color_t     hue_code;

  assign full   = pv_r & q_full;
  assign accept = push & ~full;
  assign q_push = pv_r & ~q_full;
  assign pv_nxt = accept | (pv_r & q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      alpha_r <= in_alpha;
      last_r  <= in_last_of_cell;
    end
  end

  // Hue is kept scaled by (max - min) so that the bands compare without division.
  always_comb begin
    r_max = (red_r >= green_r) && (red_r >= blue_r);
    g_max = !r_max && (green_r >= blue_r);
    mx = r_max ? red_r : (g_max ? green_r : blue_r);
    mn = red_r;
    if (green_r < mn) mn = green_r;
    if (blue_r < mn) mn = blue_r;
    d  = mx - mn;
    dw = hue_t'(d);
    if (r_max) begin
      if (green_r >= blue_r) begin
        hd = HUE_SCALE * hue_t'(green_r - blue_r);
      end else begin
        hd = HUE_FULL_TURN * dw - HUE_SCALE * hue_t'(blue_r - green_r);
      end
    end else if (g_max) begin
      if (blue_r >= red_r) begin
        hd = HUE_SECTOR_G * dw + HUE_SCALE * hue_t'(blue_r - red_r);
      end else begin
        hd = HUE_SECTOR_G * dw - HUE_SCALE * hue_t'(red_r - blue_r);
      end
    end else begin
      if (red_r >= green_r) begin
        hd = HUE_SECTOR_B * dw + HUE_SCALE * hue_t'(red_r - green_r);
      end else begin
        hd = HUE_SECTOR_B * dw - HUE_SCALE * hue_t'(green_r - red_r);
      end
    end

    if ((hd > HUE_RED_HI * dw) || (hd <= HUE_RED_LO * dw)) begin
      hue_code = COLOR_RED;
    end else if (hd <= HUE_YELLOW_HI * dw) begin
      hue_code = COLOR_YELLOW;
    end else if (hd <= HUE_GREEN_HI * dw) begin
      hue_code = COLOR_GREEN;
    end else if (hd <= HUE_CYAN_HI * dw) begin
      hue_code = COLOR_CYAN;
    end else if (hd <= HUE_BLUE_HI * dw) begin
      hue_code = COLOR_BLUE;
    end else begin
      hue_code = COLOR_MAGENTA;
    end
  end

  always_comb begin
    grey   = (red_r == green_r) && (green_r == blue_r);
    opaque = (alpha_r == 8'hFF);
    q_item.last   = last_r;
    q_item.bright = opaque && grey && (red_r > 8'd128);
    q_item.vote   = 1'b0;
    q_item.code   = hue_code;
    if (opaque) begin
      if (!grey) begin
        q_item.vote = 1'b1;
      end else if (red_r > 8'd192) begin
        q_item.vote = 1'b1;
        q_item.code = COLOR_WHITE;
      end else if (red_r inside {[8'd129:8'd191]}) begin
        q_item.vote = 1'b1;
        q_item.code = COLOR_LGREY;
      end else if (red_r inside {[8'd65:8'd127]}) begin
        q_item.vote = 1'b1;
        q_item.code = COLOR_GREY;
      end
    end
  end

endmodule

// ----- rtl/ccvq_queue.sv -----
module ccvq_queue
  import ccvq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_push,
  input  vote_item_t q_wdata,
  output logic       q_full,
  input  logic       q_pop,
  output vote_item_t q_rdata,
  output logic       q_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vote_item_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_rdata = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !q_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

// ----- rtl/ccvq_back.sv -----
module ccvq_back
  import ccvq_pkg::*;
#(
  parameter int MAX_CELL_PIXELS = 4096
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       image_mode,
  input  vote_item_t q_item,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] out_color_code
);

  localparam int CNT_W  = $clog2(MAX_CELL_PIXELS + 1);
  localparam int SLOT_W = $clog2(VOTE_SLOTS);

  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r [VOTE_SLOTS];
  logic [CNT_W-1:0] total_r, bright_r;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] best_r, best_nxt;
  color_t           best_code_r, best_code_nxt;
  logic             out_valid_r, out_valid_nxt;
  color_t           out_code_r;

  logic             take, cell_end, scan_step, emit, room;
  logic [CNT_W-1:0] cur;
  logic [CNT_W+1:0] b4, t3;
  logic [CNT_W:0]   b2;
  color_t           cloud_code, result;

  assign room     = (total_r < CNT_W'(MAX_CELL_PIXELS));
  assign take     = q_pop & room;
  assign cell_end = q_pop & q_item.last;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (!q_empty && q_item.last) state_nxt = BK_SCAN;
      end
      BK_SCAN: begin
        if (idx_r == SLOT_W'(VOTE_SLOTS - 1)) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || pop) state_nxt = BK_RUN;
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    scan_step = 1'b0;
    emit      = 1'b0;
    case (state_r)
      BK_RUN:  q_pop     = !q_empty;
      BK_SCAN: scan_step = 1'b1;
      BK_DONE: emit      = !out_valid_r || pop;
      default: q_pop     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      bright_r <= '0;
      for (int i = 0; i < VOTE_SLOTS; i++) cnt_r[i] <= '0;
    end else if (emit) begin
      total_r  <= '0;
      bright_r <= '0;
      for (int i = 0; i < VOTE_SLOTS; i++) cnt_r[i] <= '0;
    end else if (take) begin
      total_r <= total_r + 1'b1;
      if (q_item.bright) bright_r <= bright_r + 1'b1;
      for (int i = 0; i < VOTE_SLOTS; i++) begin
        if (q_item.vote && (q_item.code == color_t'(i))) cnt_r[i] <= cnt_r[i] + 1'b1;
      end
    end
  end

  assign cur = cnt_r[idx_r];

  always_comb begin
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    best_code_nxt = best_code_r;
    if (cell_end) begin
      idx_nxt       = '0;
      best_nxt      = '0;
      best_code_nxt = COLOR_NORMAL;
    end else if (scan_step) begin
      idx_nxt = idx_r + 1'b1;
      if (cur > best_r) begin
        best_nxt      = cur;
        best_code_nxt = color_t'(idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    best_r      <= best_nxt;
    best_code_r <= best_code_nxt;
  end

  always_comb begin
    b4 = {bright_r, 2'b00};
    b2 = {bright_r, 1'b0};
    t3 = {2'b00, total_r} + {1'b0, total_r, 1'b0};
    if (b4 > t3) begin
      cloud_code = COLOR_WHITE;
    end else if (b2 > {1'b0, total_r}) begin
      cloud_code = COLOR_LGREY;
    end else if (b4 > {2'b00, total_r}) begin
      cloud_code = COLOR_GREY;
    end else begin
      cloud_code = COLOR_NORMAL;
    end
    result = image_mode ? cloud_code : best_code_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_code_r <= result;
  end

  assign empty          = ~out_valid_r;
  assign out_color_code = out_code_r;

endmodule

// ----- rtl/cell_color_vote_quantizer_top.sv -----
// Colour quantiser for the pixels of one map cell.
// Pixels arrive as queue beats on push/full with red, green, blue, alpha and a
// last-of-cell flag; a beat is taken when push is high and full is low.
// Every cell yields exactly one colour code, offered on out_color_code while
// empty is low and removed by pop.
// image_mode is written over the APB port at byte address 0. The user must
// write it only while the block is idle; the block itself does not enforce this.
// 0 selects the hue and shade vote, 1 the cloud coverage ratio. Within a cell
// one pixel is taken per cycle while full is low. After the last pixel of a
// cell the vote counters are scanned one colour a cycle, and the code is then
// registered for output once any earlier result still held has been popped.
// A four-entry queue sits between the pixel classifier and the counters, so
// pixels of the next cell keep being taken while the scan runs, until it fills.
// If the receiver does not pop, one result is held and the next cell still
// counts up, then stalls before its own result.
// Reset clears the counters, the queue, the held result and image_mode.
`include "cell_color_vote_quantizer_top_defines.svh"

module cell_color_vote_quantizer_top
  import ccvq_pkg::*;
#(
  parameter int MAX_CELL_PIXELS = 4096
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic        in_last_of_cell,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_color_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       image_mode_r;
  logic       cfg_write;
  logic       q_push, q_full, q_pop, q_empty;
  vote_item_t q_wdata, q_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_IMAGE_MODE);
  assign prdata    = (paddr[2] == REG_IMAGE_MODE) ? {31'b0, image_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_mode_r <= 1'b0;
    end else if (cfg_write) begin
      image_mode_r <= pwdata[0];
    end
  end

  ccvq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .in_last_of_cell (in_last_of_cell),
    .full            (full),
    .q_push          (q_push),
    .q_item          (q_wdata),
    .q_full          (q_full)
  );

  ccvq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  ccvq_back #(
    .MAX_CELL_PIXELS (MAX_CELL_PIXELS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .image_mode     (image_mode_r),
    .q_item         (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_color_code (out_color_code)
  );

  `CCVQ_ASSERT_NOW(a_push_room, q_push, !q_full, "Classifier wrote into a full queue.")
  `CCVQ_ASSERT_NOW(a_pop_data, q_pop, !q_empty, "Counters took a beat from an empty queue.")
  `CCVQ_ASSERT_NEXT(a_full_holds, full && !q_pop, full, "Input stall dropped with no queue drain.")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
  import ccvq_pkg::*;
();

  localparam int MAX_CELL_PIX   = 4096;
  localparam int SETTLE_CYCLES  = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RESULT = 15;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CALM_FROM      = 3000;
  localparam int CALM_TO        = 4500;
  localparam logic [2:0] MODE_ADDR  = {REG_IMAGE_MODE, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic [7:0]  in_alpha = '0;
  logic        in_last_of_cell = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  out_color_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cell_color_vote_quantizer_top #(.MAX_CELL_PIXELS(MAX_CELL_PIX)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .in_last_of_cell (in_last_of_cell),
    .empty           (empty),
    .pop             (pop),
    .out_color_code  (out_color_code),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  pixel_t      pixel_queue[$];
  color_t      expected_codes[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          idle_run = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;
  logic [7:0]  band_levels [10] = '{8'd0, 8'd64, 8'd65, 8'd127, 8'd128,
                                    8'd129, 8'd191, 8'd192, 8'd193, 8'd255};

  // Shadow of the block's state.
  logic        cfg_mode = 1'b0;
  logic [12:0] vote_tally [VOTE_SLOTS];
  logic [12:0] bright_tally = '0;
  logic [12:0] pixel_tally = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic void clear_tallies();
    for (int i = 0; i < VOTE_SLOTS; i++) begin
      vote_tally[i] = '0;
    end
    bright_tally = '0;
    pixel_tally = '0;
  endfunction

  function automatic color_t hue_band(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    int mx, mn, d, hd;
    mx = int'(r);
    mn = int'(r);
    if (g > mx) mx = int'(g);
    if (b > mx) mx = int'(b);
    if (g < mn) mn = int'(g);
    if (b < mn) mn = int'(b);
    d = mx - mn;
    if (mx == r) begin
      hd = int'(HUE_SCALE) * (int'(g) - int'(b));
      if (hd < 0) hd += int'(HUE_FULL_TURN) * d;
    end else if (mx == g) begin
      hd = int'(HUE_SCALE) * (int'(b) - int'(r)) + int'(HUE_SECTOR_G) * d;
    end else begin
      hd = int'(HUE_SCALE) * (int'(r) - int'(g)) + int'(HUE_SECTOR_B) * d;
    end
    if (hd > int'(HUE_RED_HI) * d || hd <= int'(HUE_RED_LO) * d) return COLOR_RED;
    if (hd <= int'(HUE_YELLOW_HI) * d) return COLOR_YELLOW;
    if (hd <= int'(HUE_GREEN_HI) * d) return COLOR_GREEN;
    if (hd <= int'(HUE_CYAN_HI) * d) return COLOR_CYAN;
    if (hd <= int'(HUE_BLUE_HI) * d) return COLOR_BLUE;
    return COLOR_MAGENTA;
  endfunction

  function automatic color_t cell_code();
    int     best, b4, t;
    color_t code;
    if (cfg_mode) begin
      b4 = 4 * int'(bright_tally);
      t = int'(pixel_tally);
      if (b4 > 3 * t) return COLOR_WHITE;
      if (2 * int'(bright_tally) > t) return COLOR_LGREY;
      if (b4 > t) return COLOR_GREY;
      return COLOR_NORMAL;
    end
    best = 0;
    code = COLOR_NORMAL;
    for (int i = 0; i < VOTE_SLOTS; i++) begin
      if (int'(vote_tally[i]) > best) begin
        best = int'(vote_tally[i]);
        code = color_t'(i);
      end
    end
    return code;
  endfunction

  function automatic void predict_pixel(input pixel_t p);
    color_t v;
    if (int'(pixel_tally) < MAX_CELL_PIX) begin
      pixel_tally++;
      if (p.alpha == 8'd255) begin
        if (p.red == p.green && p.green == p.blue) begin
          if (p.red > 8'd128) bright_tally++;
          if (p.red > 8'd192) vote_tally[COLOR_WHITE]++;
          else if (p.red > 8'd128 && p.red < 8'd192) vote_tally[COLOR_LGREY]++;
          else if (p.red > 8'd64 && p.red < 8'd128) vote_tally[COLOR_GREY]++;
        end else begin
          v = hue_band(p.red, p.green, p.blue);
          vote_tally[v]++;
        end
      end
    end
    if (p.last) begin
      expected_codes.push_back(cell_code());
      clear_tallies();
    end
  endfunction

  initial begin
    clear_tallies();
  end

  // Pixel driver.
  always @(negedge clk) begin
    if (!rst_n || pixel_queue.size() == 0) begin
      push <= 1'b0;
    end else if (!(cycle_count >= CALM_FROM && cycle_count < CALM_TO) &&
                 $urandom_range(99) < 31) begin
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      in_red <= pixel_queue[0].red;
      in_green <= pixel_queue[0].green;
      in_blue <= pixel_queue[0].blue;
      in_alpha <= pixel_queue[0].alpha;
      in_last_of_cell <= pixel_queue[0].last;
    end
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      predict_pixel(pixel_queue[0]);
      void'(pixel_queue.pop_front());
    end
  end

  // Result receiver, with one long hold-off to make the block back up.
  always @(negedge clk) begin
    if (!held_once && results_seen >= HOLD_AT_RESULT) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (!rst_n) begin
      pop <= 1'b0;
    end else if (!(cycle_count >= CALM_FROM && cycle_count < CALM_TO) &&
                 $urandom_range(99) < 31) begin
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    color_t want;
    if (rst_n && pop && !empty) begin
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("Unexpected result beat: color_code %0d", out_color_code));
      end else begin
        want = expected_codes.pop_front();
        if (out_color_code !== want) begin
          report_mismatch($sformatf("Result %0d: color_code expected %0d, got %0d",
                                    results_seen, want, out_color_code));
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((push && !full) || (pop && !empty) || !rst_n) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr == MODE_ADDR) cfg_mode = data[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_register(input logic [2:0] addr, input logic bit0);
    logic [31:0] word, rd;
    word = $urandom;
    word[0] = bit0;
    apb_access(1'b1, addr, word, rd);
    apb_access(1'b0, MODE_ADDR, '0, rd);
    if (rd[0] !== cfg_mode) begin
      report_mismatch($sformatf("image_mode read expected %0d, got %0d", cfg_mode, rd[0]));
    end
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || push || expected_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] a, input logic last);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.last = last;
    pixel_queue.push_back(p);
  endtask

  function automatic pixel_t random_pixel(input int grey_pct);
    pixel_t     p;
    int         sel;
    logic [7:0] s, base;
    sel = $urandom_range(99);
    if (sel < grey_pct) begin
      s = $urandom_range(1) ? band_levels[$urandom_range(9)] : 8'($urandom_range(255));
      p.red = s;
      p.green = s;
      p.blue = s;
    end else if ($urandom_range(3) == 0) begin
      // Narrow channel spread lands exactly on band limits quite often.
      base = 8'($urandom_range(247));
      p.red = base + 8'($urandom_range(8));
      p.green = base + 8'($urandom_range(8));
      p.blue = base + 8'($urandom_range(8));
    end else begin
      p.red = 8'($urandom_range(255));
      p.green = 8'($urandom_range(255));
      p.blue = 8'($urandom_range(255));
    end
    p.alpha = ($urandom_range(99) < 12) ? 8'($urandom_range(254)) : 8'd255;
    p.last = 1'b0;
    return p;
  endfunction

  task automatic add_random_cells(input int n_pixels);
    int     done, len, grey_pct;
    pixel_t p;
    done = 0;
    while (done < n_pixels) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      grey_pct = $urandom_range(100);
      for (int i = 0; i < len; i++) begin
        p = random_pixel(grey_pct);
        p.last = (i == len - 1);
        pixel_queue.push_back(p);
      end
      done += len;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_register(MODE_ADDR, 1'b0);

    add_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
    add_pixel(8'd255, 8'd255, 8'd0, 8'd255, 1'b1);
    add_pixel(8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
    add_pixel(8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
    add_pixel(8'd255, 8'd0, 8'd255, 8'd255, 1'b1);
    add_pixel(8'd255, 8'd0, 8'd0, 8'd254, 1'b1);
    for (int i = 9; i >= 0; i--) begin
      if (i != 1) begin
        add_pixel(band_levels[i], band_levels[i], band_levels[i], 8'd255, i == 0);
      end
    end
    add_pixel(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
    add_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
    add_pixel(8'd4, 8'd3, 8'd0, 8'd255, 1'b1);
    // The mode is changed halfway through this cell.
    add_pixel(8'd200, 8'd200, 8'd200, 8'd255, 1'b0);
    add_pixel(8'd200, 8'd200, 8'd200, 8'd255, 1'b0);
    wait_idle();
    set_register(MODE_ADDR, 1'b1);
    add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    wait_idle();

    set_register(MODE_ADDR, 1'b0);
    set_register(SPARE_ADDR, 1'b1);
    add_random_cells(275);
    wait_idle();
    set_register(MODE_ADDR, 1'b1);
    add_random_cells(275);
    wait_idle();
    set_register(MODE_ADDR, 1'b0);
    add_random_cells(275);
    wait_idle();
    set_register(MODE_ADDR, 1'b1);
    add_random_cells(275);
    wait_idle();

    if (expected_codes.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_codes.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ccvq_pkg.sv
rtl/ccvq_front.sv
rtl/ccvq_queue.sv
rtl/ccvq_back.sv
rtl/cell_color_vote_quantizer_top.sv
sim/tb_top.sv
